/* hdl/mscol_pkg.sv */
`default_nettype none

package mscol_pkg;

	localparam int HEAP_SIZE_DEF      = 8;
	localparam int LINKS_PER_NODE_DEF = 3;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_MARK  = 2'd1;
	localparam logic [1:0] ACT_SWEEP = 2'd2;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_MARK  = 2'd1;
	localparam logic [1:0] KIND_SWEEP = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] slot;
		logic [3:0] child_a;
		logic [3:0] child_b;
		logic [3:0] child_c;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot_index;
		logic       freed;
		logic [3:0] marked_count;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINK,
		ST_POP,
		ST_SWEEP,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

/* hdl/mscol_ram.sv */
`default_nettype none

module mscol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/mark_sweep_collector_top.sv */
`default_nettype none

// Mark-and-sweep collector over a heap of HEAP_SIZE slots, each with a valid bit,
// a mark bit and LINKS_PER_NODE child links. A write item goes through ST_RESP to its
// result. A mark item walks depth first from the root, trying the highest link
// first; every step waits on the registered read of the link memory, so a push stays
// in ST_LINK and a pop passes through ST_POP back to ST_LINK. A sweep item gives
// one result per slot, one a cycle as the output register drains. The next item is
// taken once the last result is in the output register; a null, invalid or
// out-of-range root marks nothing and reports zero.

module mark_sweep_collector_top #(
	parameter int HEAP_SIZE      = mscol_pkg::HEAP_SIZE_DEF,
	parameter int LINKS_PER_NODE = mscol_pkg::LINKS_PER_NODE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mscol_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mscol_pkg::out_item_t out_data
);

	localparam int IDX_W = $clog2(HEAP_SIZE);
	localparam int LNK_W = $clog2(HEAP_SIZE + 1);
	localparam int CNT_W = $clog2(HEAP_SIZE + 1);
	localparam int LW    = LINKS_PER_NODE * LNK_W;
	localparam logic [LNK_W-1:0] NULL_LNK = LNK_W'(HEAP_SIZE);

	mscol_pkg::state_t    state_q, state_d;
	logic [HEAP_SIZE-1:0] valid_q, mark_q;
	logic [CNT_W-1:0]     depth_q, count_q;
	logic [IDX_W-1:0]     sweep_idx_q;
	logic [1:0]           rsp_kind_q;
	logic [2:0]           rsp_idx_q;
	logic                 out_valid_q;
	mscol_pkg::out_item_t out_q;

	logic [IDX_W-1:0] slot_idx;
	logic             slot_ok, root_ok, out_free, emit, push;
	logic             nxt_found;
	logic [IDX_W-1:0] nxt_slot;
	logic [LW-1:0]    new_links, link_rdata;
	logic             link_we;
	logic [IDX_W-1:0] link_raddr;
	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
	mscol_pkg::out_item_t emit_item;

	assign slot_idx = IDX_W'(in_data.slot);
	assign slot_ok  = 32'(in_data.slot) < HEAP_SIZE;
	assign root_ok  = slot_ok && valid_q[slot_idx];
	assign out_free = !out_valid_q || out_ready;
	assign push     = nxt_found && (32'(depth_q) < HEAP_SIZE);
	assign in_ready = (state_q == mscol_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// links of a written slot, out-of-range values stored as null
	always_comb begin
		logic [3:0] src;
		new_links = '0;
		for (int k = 0; k < LINKS_PER_NODE; k++) begin
			unique case (k)
				0:       src = in_data.child_a;
				1:       src = in_data.child_b;
				2:       src = in_data.child_c;
				default: src = '0;
			endcase
			new_links[k*LNK_W +: LNK_W] = (k < 3 && 32'(src) < HEAP_SIZE) ? LNK_W'(src)
			                                                              : NULL_LNK;
		end
	end

	// highest live unmarked child of the top of stack
	always_comb begin
		logic [LNK_W-1:0] lnk;
		nxt_found = 1'b0;
		nxt_slot  = '0;
		for (int k = 0; k < LINKS_PER_NODE; k++) begin
			lnk = link_rdata[k*LNK_W +: LNK_W];
			if ((32'(lnk) < HEAP_SIZE) && valid_q[IDX_W'(lnk)] && !mark_q[IDX_W'(lnk)]) begin
				nxt_found = 1'b1;
				nxt_slot  = IDX_W'(lnk);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mscol_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_data.action)
						mscol_pkg::ACT_WRITE: state_d = mscol_pkg::ST_RESP;
						mscol_pkg::ACT_MARK:  state_d = root_ok ? mscol_pkg::ST_LINK
						                                        : mscol_pkg::ST_RESP;
						mscol_pkg::ACT_SWEEP: state_d = mscol_pkg::ST_SWEEP;
						default:              state_d = mscol_pkg::ST_IDLE;
					endcase
				end
			end
			mscol_pkg::ST_LINK: begin
				if (push) begin
					state_d = mscol_pkg::ST_LINK;
				end else if (depth_q == CNT_W'(1)) begin
					state_d = mscol_pkg::ST_RESP;
				end else begin
					state_d = mscol_pkg::ST_POP;
				end
			end
			mscol_pkg::ST_POP: state_d = mscol_pkg::ST_LINK;
			mscol_pkg::ST_SWEEP: begin
				if (out_free && (32'(sweep_idx_q) == HEAP_SIZE - 1)) begin
					state_d = mscol_pkg::ST_IDLE;
				end
			end
			mscol_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = mscol_pkg::ST_IDLE;
				end
			end
			default: state_d = mscol_pkg::ST_IDLE;
		endcase
	end

	// memory ports and result
	always_comb begin
		link_we    = 1'b0;
		link_raddr = slot_idx;
		stk_we     = 1'b0;
		stk_waddr  = '0;
		stk_wdata  = slot_idx;
		stk_raddr  = IDX_W'(depth_q - CNT_W'(2));
		emit       = 1'b0;
		emit_item  = '0;
		unique case (state_q)
			mscol_pkg::ST_IDLE: begin
				if (in_valid && in_data.action == mscol_pkg::ACT_WRITE && slot_ok) begin
					link_we = 1'b1;
				end
				if (in_valid && in_data.action == mscol_pkg::ACT_MARK && root_ok) begin
					stk_we = 1'b1;
				end
			end
			mscol_pkg::ST_LINK: begin
				link_raddr = nxt_slot;
				stk_waddr  = IDX_W'(depth_q);
				stk_wdata  = nxt_slot;
				stk_we     = push;
			end
			mscol_pkg::ST_POP: begin
				link_raddr = stk_rdata;
			end
			mscol_pkg::ST_SWEEP: begin
				emit                   = out_free;
				emit_item.kind         = mscol_pkg::KIND_SWEEP;
				emit_item.slot_index   = 3'(sweep_idx_q);
				emit_item.freed        = valid_q[sweep_idx_q] && !mark_q[sweep_idx_q];
				emit_item.marked_count = '0;
				emit_item.last         = (32'(sweep_idx_q) == HEAP_SIZE - 1);
			end
			mscol_pkg::ST_RESP: begin
				emit                   = out_free;
				emit_item.kind         = rsp_kind_q;
				emit_item.slot_index   = rsp_idx_q;
				emit_item.freed        = 1'b0;
				emit_item.marked_count = 4'(count_q);
				emit_item.last         = 1'b1;
			end
			default: ;
		endcase
	end

	mscol_ram #(
		.WIDTH (LW),
		.DEPTH (HEAP_SIZE)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (slot_idx),
		.wdata (new_links),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	mscol_ram #(
		.WIDTH (IDX_W),
		.DEPTH (HEAP_SIZE)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mscol_pkg::ST_IDLE;
			valid_q     <= '0;
			mark_q      <= '0;
			depth_q     <= '0;
			count_q     <= '0;
			sweep_idx_q <= '0;
			rsp_kind_q  <= '0;
			rsp_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mscol_pkg::ST_IDLE: begin
					if (in_valid) begin
						case (in_data.action)
							mscol_pkg::ACT_WRITE: begin
								if (slot_ok) begin
									valid_q[slot_idx] <= 1'b1;
									mark_q[slot_idx]  <= 1'b0;
								end
								rsp_kind_q <= mscol_pkg::KIND_WRITE;
								rsp_idx_q  <= in_data.slot[2:0];
								count_q    <= '0;
							end
							mscol_pkg::ACT_MARK: begin
								rsp_kind_q <= mscol_pkg::KIND_MARK;
								rsp_idx_q  <= '0;
								count_q    <= root_ok ? CNT_W'(!mark_q[slot_idx]) : '0;
								if (root_ok) begin
									mark_q[slot_idx] <= 1'b1;
									depth_q <= CNT_W'(1);
								end
							end
							mscol_pkg::ACT_SWEEP: sweep_idx_q <= '0;
							default: ;
						endcase
					end
				end
				mscol_pkg::ST_LINK: begin
					if (push) begin
						mark_q[nxt_slot] <= 1'b1;
						count_q <= count_q + CNT_W'(1);
						depth_q <= depth_q + CNT_W'(1);
					end else begin
						depth_q <= depth_q - CNT_W'(1);
					end
				end
				mscol_pkg::ST_SWEEP: begin
					if (out_free) begin
						if (valid_q[sweep_idx_q] && !mark_q[sweep_idx_q]) begin
							valid_q[sweep_idx_q] <= 1'b0;
						end
						sweep_idx_q <= sweep_idx_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
	end

endmodule

`default_nettype wire

/* hdl/mscol_checker.sv */
`default_nettype none

module mscol_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input mscol_pkg::in_item_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input mscol_pkg::out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// any real item makes the block busy in the cycle after it is taken
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.action == mscol_pkg::ACT_WRITE
			|| in_data.action == mscol_pkg::ACT_MARK
			|| in_data.action == mscol_pkg::ACT_SWEEP) |=> !in_ready)
		else $error("input taken again before results");

	// single-result items end at once and free nothing
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != mscol_pkg::KIND_SWEEP |-> out_data.last && !out_data.freed)
		else $error("write or mark result malformed");

	// sweep still running while a report that is not the last waits
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == mscol_pkg::KIND_SWEEP && !out_data.last
		|-> !in_ready)
		else $error("input taken during sweep");

endmodule

bind mark_sweep_collector_top mscol_checker u_chk (.*);

`default_nettype wire
